[design/assert_macros.svh]
// assertion helpers shared by the design files
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication
`define ASSERT_IMPL(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |-> (cons)) \
        else $error("assertion failed");

// next-cycle implication
`define ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!(rst_n)) (ante) |=> (cons)) \
        else $error("assertion failed");

`endif

[design/pl0ls_pkg.sv]
package pl0ls_pkg;

    localparam int NAME_MAX   = 11;
    localparam int DIGITS_MAX = 5;
    localparam int NAME_OUT   = 11;
    localparam int QDEPTH     = 4;
    localparam int QPTR_W     = $clog2(QDEPTH);
    localparam int QCNT_W     = $clog2(QDEPTH + 1);
    localparam int NUM_W      = 17;
    localparam int WC_W       = $clog2(NAME_MAX + 2);
    localparam int WI_W       = $clog2(NAME_MAX);
    localparam int DC_W       = $clog2(DIGITS_MAX + 2);
    localparam int KW_NUM     = 12;

    localparam logic [5:0] TK_NONE    = 6'd0;
    localparam logic [5:0] TK_ODD     = 6'd1;
    localparam logic [5:0] TK_IDENT   = 6'd2;
    localparam logic [5:0] TK_NUMBER  = 6'd3;
    localparam logic [5:0] TK_PLUS    = 6'd4;
    localparam logic [5:0] TK_MINUS   = 6'd5;
    localparam logic [5:0] TK_TIMES   = 6'd6;
    localparam logic [5:0] TK_SLASH   = 6'd7;
    localparam logic [5:0] TK_FI      = 6'd8;
    localparam logic [5:0] TK_EQL     = 6'd9;
    localparam logic [5:0] TK_NEQ     = 6'd10;
    localparam logic [5:0] TK_LSS     = 6'd11;
    localparam logic [5:0] TK_LEQ     = 6'd12;
    localparam logic [5:0] TK_GTR     = 6'd13;
    localparam logic [5:0] TK_GEQ     = 6'd14;
    localparam logic [5:0] TK_LPAREN  = 6'd15;
    localparam logic [5:0] TK_RPAREN  = 6'd16;
    localparam logic [5:0] TK_COMMA   = 6'd17;
    localparam logic [5:0] TK_SEMI    = 6'd18;
    localparam logic [5:0] TK_PERIOD  = 6'd19;
    localparam logic [5:0] TK_BECOMES = 6'd20;
    localparam logic [5:0] TK_BEGIN   = 6'd21;
    localparam logic [5:0] TK_END     = 6'd22;
    localparam logic [5:0] TK_IF      = 6'd23;
    localparam logic [5:0] TK_THEN    = 6'd24;
    localparam logic [5:0] TK_WHILE   = 6'd25;
    localparam logic [5:0] TK_DO      = 6'd26;
    localparam logic [5:0] TK_CONST   = 6'd28;
    localparam logic [5:0] TK_VAR     = 6'd29;
    localparam logic [5:0] TK_WRITE   = 6'd31;
    localparam logic [5:0] TK_READ    = 6'd32;

    localparam logic [1:0] ERR_NONE   = 2'd0;
    localparam logic [1:0] ERR_SYMBOL = 2'd1;
    localparam logic [1:0] ERR_NAME   = 2'd2;
    localparam logic [1:0] ERR_NUMBER = 2'd3;

    localparam logic [7:0] CH_SPACE   = 8'd32;
    localparam logic [7:0] CH_LPAREN  = 8'd40;
    localparam logic [7:0] CH_RPAREN  = 8'd41;
    localparam logic [7:0] CH_STAR    = 8'd42;
    localparam logic [7:0] CH_PLUS    = 8'd43;
    localparam logic [7:0] CH_COMMA   = 8'd44;
    localparam logic [7:0] CH_MINUS   = 8'd45;
    localparam logic [7:0] CH_PERIOD  = 8'd46;
    localparam logic [7:0] CH_SLASH   = 8'd47;
    localparam logic [7:0] CH_ZERO    = 8'd48;
    localparam logic [7:0] CH_NINE    = 8'd57;
    localparam logic [7:0] CH_COLON   = 8'd58;
    localparam logic [7:0] CH_SEMI    = 8'd59;
    localparam logic [7:0] CH_LESS    = 8'd60;
    localparam logic [7:0] CH_EQUAL   = 8'd61;
    localparam logic [7:0] CH_GREATER = 8'd62;
    localparam logic [7:0] CH_UP_A    = 8'd65;
    localparam logic [7:0] CH_UP_Z    = 8'd90;
    localparam logic [7:0] CH_LO_A    = 8'd97;
    localparam logic [7:0] CH_LO_Z    = 8'd122;

    typedef struct packed {
        logic [7:0] char_byte;
        logic       end_of_input;
    } t_in_item;

    typedef struct packed {
        logic [5:0]       token_code;
        logic [NUM_W-1:0] number_value;
        logic [3:0]       name_length;
        logic [63:0]      name_high;
        logic [23:0]      name_low;
        logic [1:0]       error_code;
        logic             last;
    } t_out_item;

    typedef struct packed {
        logic [5:0]       token_code;
        logic [NUM_W-1:0] number_value;
        logic [3:0]       name_length;
        logic [63:0]      name_high;
        logic [23:0]      name_low;
        logic [1:0]       error_code;
    } t_tok;

    // a record holds the one or two tokens of one scanned byte
    typedef struct packed {
        t_tok t0;
        t_tok t1;
        logic two;
    } t_rec;

    // keyword text, first character in the top byte, zero padded
    localparam logic [39:0] KW_TEXT [KW_NUM] = '{
        40'h636f6e7374, 40'h7661720000, 40'h626567696e, 40'h656e640000,
        40'h6966000000, 40'h6669000000, 40'h7468656e00, 40'h7768696c65,
        40'h646f000000, 40'h7265616400, 40'h7772697465, 40'h6f64640000
    };
    localparam logic [3:0] KW_LEN [KW_NUM] = '{
        4'd5, 4'd3, 4'd5, 4'd3, 4'd2, 4'd2, 4'd4, 4'd5, 4'd2, 4'd4, 4'd5, 4'd3
    };
    localparam logic [5:0] KW_CODE [KW_NUM] = '{
        TK_CONST, TK_VAR, TK_BEGIN, TK_END, TK_IF, TK_FI,
        TK_THEN, TK_WHILE, TK_DO, TK_READ, TK_WRITE, TK_ODD
    };

    function automatic logic [5:0] kw_code(input logic [39:0] head,
                                           input logic [WC_W-1:0] count);
        logic [5:0] code;
        code = TK_NONE;
        for (int k = 0; k < KW_NUM; k++) begin
            if (count == WC_W'(KW_LEN[k]) && head == KW_TEXT[k]) begin
                code = KW_CODE[k];
            end
        end
        return code;
    endfunction

    function automatic logic is_letter(input logic [7:0] b);
        return b inside {[CH_UP_A:CH_UP_Z], [CH_LO_A:CH_LO_Z]};
    endfunction

    function automatic logic is_digit(input logic [7:0] b);
        return b inside {[CH_ZERO:CH_NINE]};
    endfunction

    function automatic t_tok mk_tok(input logic [5:0] code);
        t_tok t;
        t = '0;
        t.token_code = code;
        return t;
    endfunction

    function automatic t_tok mk_err(input logic [1:0] err);
        t_tok t;
        t = '0;
        t.error_code = err;
        return t;
    endfunction

endpackage

[design/pl0ls_front.sv]
`include "assert_macros.svh"

module pl0ls_front import pl0ls_pkg::*; (
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  logic     i_valid,
    input  t_in_item i_item,
    output logic     o_push,
    output t_rec     o_rec
);

    typedef enum logic [4:0] {
        M_IDLE = 5'b00001,
        M_WORD = 5'b00010,
        M_NUM  = 5'b00100,
        M_OP   = 5'b01000,
        M_CMT  = 5'b10000
    } t_mode;

    t_mode                       r_mode, n_mode;
    logic [NAME_MAX-1:0][7:0]    r_word, n_word;
    logic [WC_W-1:0]             r_wcnt, n_wcnt;
    logic [NUM_W-1:0]            r_acc, n_acc;
    logic [DC_W-1:0]             r_dcnt, n_dcnt;
    logic [7:0]                  r_pend, n_pend;
    logic [7:0]                  r_cprev, n_cprev;
    logic                        r_stop, n_stop;

    logic       [7:0] b;
    logic             eoi, letter, digit;
    logic             f_emit, f_stop;
    t_mode            f_mode;
    t_tok             f_tok;
    logic             w_err, d_err, p_err;
    t_tok             w_tok, d_tok, p_tok, id_tok;
    logic       [5:0] kw;
    logic             a_v, a_stop, s_v, take_fresh;
    t_tok             a_t, s_t;

    always_comb begin
        b      = i_item.char_byte;
        eoi    = i_item.end_of_input;
        letter = is_letter(b);
        digit  = is_digit(b);

        // scan of a byte between tokens
        f_emit = 1'b0;
        f_stop = 1'b0;
        f_mode = M_IDLE;
        f_tok  = mk_tok(TK_NONE);
        if (b > CH_SPACE) begin
            if (letter) begin
                f_mode = M_WORD;
            end else if (digit) begin
                f_mode = M_NUM;
            end else begin
                f_emit = 1'b1;
                case (b)
                    CH_SLASH, CH_COLON, CH_LESS, CH_GREATER: begin
                        f_emit = 1'b0;
                        f_mode = M_OP;
                    end
                    CH_PERIOD: begin
                        f_tok  = mk_tok(TK_PERIOD);
                        f_stop = 1'b1;
                    end
                    CH_LPAREN:  f_tok = mk_tok(TK_LPAREN);
                    CH_RPAREN:  f_tok = mk_tok(TK_RPAREN);
                    CH_STAR:    f_tok = mk_tok(TK_TIMES);
                    CH_PLUS:    f_tok = mk_tok(TK_PLUS);
                    CH_COMMA:   f_tok = mk_tok(TK_COMMA);
                    CH_MINUS:   f_tok = mk_tok(TK_MINUS);
                    CH_SEMI:    f_tok = mk_tok(TK_SEMI);
                    CH_EQUAL:   f_tok = mk_tok(TK_EQL);
                    default: begin
                        f_tok  = mk_err(ERR_SYMBOL);
                        f_stop = 1'b1;
                    end
                endcase
            end
        end

        // finished word
        id_tok             = mk_tok(TK_IDENT);
        id_tok.name_length = 4'(r_wcnt);
        for (int i = 0; i < 8; i++) begin
            id_tok.name_high[63 - 8*i -: 8] = r_word[i];
        end
        for (int i = 8; i < NAME_OUT; i++) begin
            id_tok.name_low[23 - 8*(i-8) -: 8] = r_word[i];
        end
        kw    = kw_code({r_word[0], r_word[1], r_word[2], r_word[3], r_word[4]}, r_wcnt);
        w_err = r_wcnt > WC_W'(NAME_MAX);
        if (w_err) begin
            w_tok = mk_err(ERR_NAME);
        end else if (kw != TK_NONE) begin
            w_tok = mk_tok(kw);
        end else begin
            w_tok = id_tok;
        end

        // finished number
        d_err = r_dcnt > DC_W'(DIGITS_MAX);
        d_tok = mk_tok(TK_NUMBER);
        d_tok.number_value = r_acc;
        if (d_err) begin
            d_tok = mk_err(ERR_NUMBER);
        end

        // pending operator with no partner
        p_err = 1'b0;
        case (r_pend)
            CH_SLASH:   p_tok = mk_tok(TK_SLASH);
            CH_LESS:    p_tok = mk_tok(TK_LSS);
            CH_GREATER: p_tok = mk_tok(TK_GTR);
            default: begin
                p_tok = mk_err(ERR_SYMBOL);
                p_err = 1'b1;
            end
        endcase

        n_mode     = r_mode;
        n_word     = r_word;
        n_wcnt     = r_wcnt;
        n_acc      = r_acc;
        n_dcnt     = r_dcnt;
        n_pend     = r_pend;
        n_cprev    = r_cprev;
        n_stop     = r_stop;
        a_v        = 1'b0;
        a_t        = mk_tok(TK_NONE);
        a_stop     = 1'b0;
        s_v        = 1'b0;
        s_t        = mk_tok(TK_NONE);
        take_fresh = 1'b0;

        if (i_valid && !r_stop) begin
            if (eoi) begin
                case (r_mode)
                    M_WORD: begin
                        a_v = 1'b1; a_t = w_tok; a_stop = w_err;
                    end
                    M_NUM: begin
                        a_v = 1'b1; a_t = d_tok; a_stop = d_err;
                    end
                    M_OP: begin
                        a_v = 1'b1; a_t = p_tok; a_stop = p_err;
                    end
                    default: ;
                endcase
                n_mode = M_IDLE;
                n_pend = '0;
                s_v    = !a_stop;
                s_t    = mk_err(ERR_SYMBOL);
                n_stop = 1'b1;
            end else begin
                case (r_mode)
                    M_WORD: begin
                        if (letter || digit) begin
                            if (r_wcnt < WC_W'(NAME_MAX)) begin
                                n_word[r_wcnt[WI_W-1:0]] = b;
                            end
                            if (r_wcnt <= WC_W'(NAME_MAX)) begin
                                n_wcnt = r_wcnt + 1'b1;
                            end
                        end else begin
                            a_v = 1'b1; a_t = w_tok; a_stop = w_err;
                            n_mode     = M_IDLE;
                            take_fresh = !w_err;
                        end
                    end
                    M_NUM: begin
                        if (digit) begin
                            if (r_dcnt < DC_W'(DIGITS_MAX)) begin
                                n_acc = (r_acc << 3) + (r_acc << 1)
                                      + NUM_W'(b - CH_ZERO);
                            end
                            if (r_dcnt <= DC_W'(DIGITS_MAX)) begin
                                n_dcnt = r_dcnt + 1'b1;
                            end
                        end else begin
                            a_v = 1'b1; a_t = d_tok; a_stop = d_err;
                            n_mode     = M_IDLE;
                            take_fresh = !d_err;
                        end
                    end
                    M_OP: begin
                        n_mode = M_IDLE;
                        n_pend = '0;
                        if (r_pend == CH_SLASH && b == CH_STAR) begin
                            n_mode  = M_CMT;
                            n_cprev = CH_STAR;
                        end else if (r_pend == CH_COLON && b == CH_EQUAL) begin
                            a_v = 1'b1; a_t = mk_tok(TK_BECOMES);
                        end else if (r_pend == CH_LESS && b == CH_GREATER) begin
                            a_v = 1'b1; a_t = mk_tok(TK_NEQ);
                        end else if (r_pend == CH_LESS && b == CH_EQUAL) begin
                            a_v = 1'b1; a_t = mk_tok(TK_LEQ);
                        end else if (r_pend == CH_GREATER && b == CH_EQUAL) begin
                            a_v = 1'b1; a_t = mk_tok(TK_GEQ);
                        end else begin
                            a_v = 1'b1; a_t = p_tok; a_stop = p_err;
                            take_fresh = !p_err;
                        end
                    end
                    M_CMT: begin
                        if (b == CH_SLASH && r_cprev == CH_STAR) begin
                            n_mode  = M_IDLE;
                            n_cprev = '0;
                        end else begin
                            n_cprev = b;
                        end
                    end
                    default: begin
                        take_fresh = 1'b1;
                    end
                endcase

                if (take_fresh) begin
                    s_v    = f_emit;
                    s_t    = f_tok;
                    n_mode = f_mode;
                    case (f_mode)
                        M_WORD: begin
                            n_word    = '0;
                            n_word[0] = b;
                            n_wcnt    = WC_W'(1);
                        end
                        M_NUM: begin
                            n_acc  = NUM_W'(b - CH_ZERO);
                            n_dcnt = DC_W'(1);
                        end
                        M_OP: n_pend = b;
                        default: ;
                    endcase
                end
                n_stop = a_stop || (take_fresh && f_stop);
            end
        end

        o_push   = a_v || s_v;
        o_rec.t0 = a_v ? a_t : s_t;
        o_rec.t1 = s_t;
        o_rec.two = a_v && s_v;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mode  <= M_IDLE;
            r_wcnt  <= '0;
            r_dcnt  <= '0;
            r_pend  <= '0;
            r_cprev <= '0;
            r_stop  <= 1'b0;
        end else begin
            r_mode  <= n_mode;
            r_wcnt  <= n_wcnt;
            r_dcnt  <= n_dcnt;
            r_pend  <= n_pend;
            r_cprev <= n_cprev;
            r_stop  <= n_stop;
        end
    end

    always_ff @(posedge i_clk) begin
        r_word <= n_word;
        r_acc  <= n_acc;
    end

    `ASSERT_IMPL(a_quiet_when_stopped, i_clk, i_rst_n, r_stop, !o_push)
    `ASSERT_NEXT(a_error_stops, i_clk, i_rst_n,
        o_push && (o_rec.t0.error_code != ERR_NONE || o_rec.t1.error_code != ERR_NONE),
        r_stop)

endmodule

[design/pl0ls_queue.sv]
`include "assert_macros.svh"

module pl0ls_queue import pl0ls_pkg::*; (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_push,
    input  t_rec i_rec,
    output logic o_full,
    input  logic i_pop,
    output logic o_empty,
    output t_rec o_rec
);

    t_rec              r_mem [QDEPTH];
    logic [QPTR_W-1:0] r_wp, n_wp;
    logic [QPTR_W-1:0] r_rp, n_rp;
    logic [QCNT_W-1:0] r_cnt, n_cnt;
    t_rec              r_out;
    logic              r_ov, n_ov;
    logic              do_push, do_pop, do_load;

    always_comb begin
        o_full  = r_cnt == QCNT_W'(QDEPTH);
        o_empty = !r_ov;
        do_push = i_push && !o_full;
        do_pop  = i_pop && r_ov;
        // refill the output register from the memory
        do_load = (r_cnt != '0) && (!r_ov || do_pop);
        n_wp    = r_wp + QPTR_W'(do_push);
        n_rp    = r_rp + QPTR_W'(do_load);
        n_cnt   = r_cnt + QCNT_W'(do_push) - QCNT_W'(do_load);
        n_ov    = do_load || (r_ov && !do_pop);
        o_rec   = r_out;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= '0;
            r_rp  <= '0;
            r_cnt <= '0;
            r_ov  <= 1'b0;
        end else begin
            r_wp  <= n_wp;
            r_rp  <= n_rp;
            r_cnt <= n_cnt;
            r_ov  <= n_ov;
        end
    end

    always_ff @(posedge i_clk) begin
        if (do_push) begin
            r_mem[r_wp] <= i_rec;
        end
        if (do_load) begin
            r_out <= r_mem[r_rp];
        end
    end

    `ASSERT_IMPL(a_count_range, i_clk, i_rst_n, 1'b1, r_cnt <= QCNT_W'(QDEPTH))
    `ASSERT_NEXT(a_out_held, i_clk, i_rst_n, r_ov && !i_pop, r_ov && $stable(r_out))

endmodule

[design/pl0ls_back.sv]
`include "assert_macros.svh"

module pl0ls_back import pl0ls_pkg::*; (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_q_empty,
    input  t_rec      i_q_rec,
    output logic      o_q_pop,
    output logic      o_empty,
    input  logic      i_pop,
    output t_out_item o_data
);

    t_rec r_rec;
    logic r_valid, n_valid;
    logic r_idx, n_idx;
    logic fin, done;
    t_tok cur;

    always_comb begin
        fin     = r_idx || !r_rec.two;
        done    = r_valid && i_pop && fin;
        o_q_pop = !i_q_empty && (!r_valid || done);
        n_valid = r_valid;
        n_idx   = r_idx;
        if (o_q_pop) begin
            n_valid = 1'b1;
            n_idx   = 1'b0;
        end else if (done) begin
            n_valid = 1'b0;
            n_idx   = 1'b0;
        end else if (r_valid && i_pop) begin
            n_idx = 1'b1;
        end

        o_empty = !r_valid;
        cur     = r_idx ? r_rec.t1 : r_rec.t0;
        o_data.token_code   = cur.token_code;
        o_data.number_value = cur.number_value;
        o_data.name_length  = cur.name_length;
        o_data.name_high    = cur.name_high;
        o_data.name_low     = cur.name_low;
        o_data.error_code   = cur.error_code;
        o_data.last         = fin;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
            r_idx   <= 1'b0;
        end else begin
            r_valid <= n_valid;
            r_idx   <= n_idx;
        end
    end

    always_ff @(posedge i_clk) begin
        if (o_q_pop) begin
            r_rec <= i_q_rec;
        end
    end

    `ASSERT_NEXT(a_hold_unpopped, i_clk, i_rst_n, r_valid && !i_pop,
        r_valid && $stable(r_idx))

endmodule

[design/pl0_lexical_scanner_top.sv]
// path: a byte's tokens go from the scanner through a four-entry queue, which
// absorbs bursts, its registered read stage and the result register
// throughput: one byte per cycle while the queue is not full; a byte that
// yields two tokens holds the result port until both of them are popped
// reset: synchronous, active low; clears scanner mode, counters, queue
// pointers and the output stage, with no clearing pass
module pl0_lexical_scanner_top import pl0ls_pkg::*; (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      push,
    output logic      full,
    input  t_in_item  i_data,
    output logic      empty,
    input  logic      pop,
    output t_out_item o_data
);

    logic f_push;
    t_rec f_rec;
    logic q_empty;
    logic q_pop;
    t_rec q_rec;

    pl0ls_front u_front (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_valid (push && !full),
        .i_item  (i_data),
        .o_push  (f_push),
        .o_rec   (f_rec)
    );

    pl0ls_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (f_push),
        .i_rec   (f_rec),
        .o_full  (full),
        .i_pop   (q_pop),
        .o_empty (q_empty),
        .o_rec   (q_rec)
    );

    pl0ls_back u_back (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_q_empty (q_empty),
        .i_q_rec   (q_rec),
        .o_q_pop   (q_pop),
        .o_empty   (empty),
        .i_pop     (pop),
        .o_data    (o_data)
    );

endmodule

[tb/sv/tb.sv]
module tb;
    import pl0ls_pkg::*;

    localparam int LIMIT   = 1_000_000;
    localparam int N_ITEMS = 1600;

    typedef enum logic [2:0] {
        SC_IDLE, SC_WORD, SC_NUMBER, SC_OP, SC_COMMENT
    } t_scan;

    typedef enum int {TAIL_OTHER, TAIL_WORD, TAIL_NUM, TAIL_SLASH} t_tail;

    class token_board;
        t_scan            mode;
        logic [7:0]       word [NAME_MAX];
        int               word_len;
        logic [NUM_W-1:0] value;
        int               digits;
        logic [7:0]       pend_op;
        logic [7:0]       prev_ch;
        bit               halted;
        t_out_item        due [$];
        t_out_item        step_toks [$];
        int               errors;
        int               inputs;
        int               tokens;
        string            kw_text [12];
        logic [5:0]       kw_tok [12];

        function new();
            kw_text = '{"const", "var", "begin", "end", "if", "fi",
                        "then", "while", "do", "read", "write", "odd"};
            kw_tok = '{TK_CONST, TK_VAR, TK_BEGIN, TK_END, TK_IF, TK_FI,
                       TK_THEN, TK_WHILE, TK_DO, TK_READ, TK_WRITE, TK_ODD};
            mode = SC_IDLE;
            foreach (word[i]) word[i] = '0;
            word_len = 0;
            value = '0;
            digits = 0;
            pend_op = '0;
            prev_ch = '0;
            halted = 1'b0;
            errors = 0;
            inputs = 0;
            tokens = 0;
        endfunction

        static function bit alpha(logic [7:0] b);
            return (b >= CH_UP_A && b <= CH_UP_Z) || (b >= CH_LO_A && b <= CH_LO_Z);
        endfunction

        static function bit numeral(logic [7:0] b);
            return b >= CH_ZERO && b <= CH_NINE;
        endfunction

        function void report(string what, logic [63:0] got, logic [63:0] want);
            errors++;
            if (errors <= 30)
                $display("tb: %s mismatch, got %0h, want %0h", what, got, want);
        endfunction

        function void put(logic [5:0] code, logic [1:0] err = ERR_NONE,
                          logic [NUM_W-1:0] num = '0, logic [3:0] len = '0,
                          logic [63:0] hi = '0, logic [23:0] lo = '0);
            t_out_item r;
            r = '0;
            r.token_code = code;
            r.number_value = num;
            r.name_length = len;
            r.name_high = hi;
            r.name_low = lo;
            r.error_code = err;
            step_toks.push_back(r);
        endfunction

        function void halt_with(logic [1:0] err);
            halted = 1'b1;
            put(TK_NONE, err);
        endfunction

        function void end_word();
            logic [63:0] hi;
            logic [23:0] lo;
            bit hit;
            mode = SC_IDLE;
            if (word_len > NAME_MAX) begin
                halt_with(ERR_NAME);
                return;
            end
            for (int k = 0; k < 12; k++) begin
                if (kw_text[k].len() == word_len) begin
                    hit = 1'b1;
                    for (int i = 0; i < word_len; i++)
                        if (kw_text[k][i] != word[i]) hit = 1'b0;
                    if (hit) begin
                        put(kw_tok[k]);
                        return;
                    end
                end
            end
            hi = '0;
            lo = '0;
            for (int i = 0; i < 8; i++)
                hi = {hi[55:0], ((i < word_len) ? word[i] : 8'h00)};
            for (int i = 8; i < 11; i++)
                lo = {lo[15:0], ((i < word_len) ? word[i] : 8'h00)};
            put(TK_IDENT, ERR_NONE, '0, 4'(word_len), hi, lo);
        endfunction

        function void end_number();
            mode = SC_IDLE;
            if (digits > DIGITS_MAX)
                halt_with(ERR_NUMBER);
            else
                put(TK_NUMBER, ERR_NONE, value);
        endfunction

        function void flush_op(logic [7:0] p);
            case (p)
                CH_SLASH:   put(TK_SLASH);
                CH_LESS:    put(TK_LSS);
                CH_GREATER: put(TK_GTR);
                default:    halt_with(ERR_SYMBOL);
            endcase
        endfunction

        function void fresh(logic [7:0] b);
            if (b <= CH_SPACE) return;
            if (alpha(b)) begin
                mode = SC_WORD;
                foreach (word[i]) word[i] = '0;
                word[0] = b;
                word_len = 1;
                return;
            end
            if (numeral(b)) begin
                mode = SC_NUMBER;
                value = NUM_W'(b - CH_ZERO);
                digits = 1;
                return;
            end
            case (b)
                CH_SLASH, CH_COLON, CH_LESS, CH_GREATER: begin
                    mode = SC_OP;
                    pend_op = b;
                end
                CH_PERIOD: begin
                    halted = 1'b1;
                    put(TK_PERIOD);
                end
                CH_LPAREN: put(TK_LPAREN);
                CH_RPAREN: put(TK_RPAREN);
                CH_STAR:   put(TK_TIMES);
                CH_PLUS:   put(TK_PLUS);
                CH_COMMA:  put(TK_COMMA);
                CH_MINUS:  put(TK_MINUS);
                CH_SEMI:   put(TK_SEMI);
                CH_EQUAL:  put(TK_EQL);
                default:   halt_with(ERR_SYMBOL);
            endcase
        endfunction

        // predicts the tokens of one accepted byte
        function void note(t_in_item it);
            logic [7:0] b;
            logic [7:0] p;
            b = it.char_byte;
            inputs++;
            step_toks.delete();
            if (halted) return;
            if (it.end_of_input) begin
                case (mode)
                    SC_WORD:   end_word();
                    SC_NUMBER: end_number();
                    SC_OP:     flush_op(pend_op);
                    default:   ;
                endcase
                mode = SC_IDLE;
                pend_op = '0;
                if (!halted) halt_with(ERR_SYMBOL);
            end else begin
                case (mode)
                    SC_WORD: begin
                        if (alpha(b) || numeral(b)) begin
                            if (word_len < NAME_MAX) word[word_len] = b;
                            if (word_len <= NAME_MAX) word_len++;
                        end else begin
                            end_word();
                            if (!halted) fresh(b);
                        end
                    end
                    SC_NUMBER: begin
                        if (numeral(b)) begin
                            if (digits < DIGITS_MAX) value = value * 10 + (b - CH_ZERO);
                            if (digits <= DIGITS_MAX) digits++;
                        end else begin
                            end_number();
                            if (!halted) fresh(b);
                        end
                    end
                    SC_OP: begin
                        p = pend_op;
                        mode = SC_IDLE;
                        pend_op = '0;
                        if (p == CH_SLASH && b == CH_STAR) begin
                            mode = SC_COMMENT;
                            prev_ch = CH_STAR;
                        end else if (p == CH_COLON && b == CH_EQUAL) begin
                            put(TK_BECOMES);
                        end else if (p == CH_LESS && b == CH_GREATER) begin
                            put(TK_NEQ);
                        end else if (p == CH_LESS && b == CH_EQUAL) begin
                            put(TK_LEQ);
                        end else if (p == CH_GREATER && b == CH_EQUAL) begin
                            put(TK_GEQ);
                        end else begin
                            flush_op(p);
                            if (!halted) fresh(b);
                        end
                    end
                    SC_COMMENT: begin
                        if (b == CH_SLASH && prev_ch == CH_STAR) begin
                            mode = SC_IDLE;
                            prev_ch = '0;
                        end else begin
                            prev_ch = b;
                        end
                    end
                    default: fresh(b);
                endcase
            end
            if (step_toks.size() > 0) step_toks[$].last = 1'b1;
            foreach (step_toks[i]) due.push_back(step_toks[i]);
        endfunction

        function void check(t_out_item got);
            t_out_item want;
            if (due.size() == 0) begin
                report("unexpected token", got.token_code, '0);
                return;
            end
            want = due.pop_front();
            tokens++;
            if (got.token_code !== want.token_code)
                report("token_code", got.token_code, want.token_code);
            if (got.number_value !== want.number_value)
                report("number_value", got.number_value, want.number_value);
            if (got.name_length !== want.name_length)
                report("name_length", got.name_length, want.name_length);
            if (got.name_high !== want.name_high)
                report("name_high", got.name_high, want.name_high);
            if (got.name_low !== want.name_low)
                report("name_low", got.name_low, want.name_low);
            if (got.error_code !== want.error_code)
                report("error_code", got.error_code, want.error_code);
            if (got.last !== want.last)
                report("last", got.last, want.last);
        endfunction
    endclass

    logic      i_clk;
    logic      i_rst_n = 1'b0;
    logic      push = 1'b0;
    logic      full;
    t_in_item  i_data = '0;
    logic      empty;
    logic      pop = 1'b0;
    t_out_item o_data;

    token_board sb;
    bit         calm = 1'b0;
    int         sent = 0;
    t_in_item   text [$];
    logic [7:0] piece [$];
    t_tail      tail_kind = TAIL_OTHER;
    string      ending = "";

    pl0_lexical_scanner_top uut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .push    (push),
        .full    (full),
        .i_data  (i_data),
        .empty   (empty),
        .pop     (pop),
        .o_data  (o_data)
    );

    initial begin
        i_clk = 1'b0;
        forever #10 i_clk = ~i_clk;
    end

    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (push && !full) sb.note(i_data);
            if (pop && !empty) sb.check(o_data);
        end
    end

    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (calm || r < 55) return 0;
        if (r < 88) return $urandom_range(1, 3);
        if (r < 97) return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    // stretches with and without idling
    initial begin
        forever begin
            repeat ($urandom_range(150, 600)) @(posedge i_clk);
            calm <= ~calm;
        end
    end

    initial begin
        int hold;
        hold = 0;
        forever begin
            @(posedge i_clk);
            if (hold > 0) begin
                pop <= 1'b0;
                hold--;
            end else begin
                pop <= 1'b1;
                hold = pick_gap();
            end
        end
    end

    initial begin
        for (int n = 0; n < LIMIT; n++) @(posedge i_clk);
        $display("tb: run did not drain within %0d cycles", LIMIT);
        $display("tb: errors");
        $finish;
    end

    function automatic logic [7:0] rand_alpha();
        int r;
        r = $urandom_range(0, 51);
        return (r < 26) ? CH_UP_A + 8'(r) : CH_LO_A + 8'(r - 26);
    endfunction

    function automatic logic [7:0] rand_alnum();
        int r;
        r = $urandom_range(0, 61);
        return (r < 10) ? CH_ZERO + 8'(r) : rand_alpha();
    endfunction

    function automatic void add(logic [7:0] b);
        piece.push_back(b);
    endfunction

    function automatic void put_text(string s);
        for (int i = 0; i < s.len(); i++) text.push_back({s[i], 1'b0});
    endfunction

    // moves a token into the stream, with a separator where it would merge and at random elsewhere
    function automatic void commit(t_tail kind);
        logic [7:0] first;
        bit need;
        if (piece.size() == 0) return;
        first = piece[0];
        need = (tail_kind == TAIL_WORD && (token_board::alpha(first) ||
                                           token_board::numeral(first))) ||
               (tail_kind == TAIL_NUM && token_board::numeral(first)) ||
               (tail_kind == TAIL_SLASH && first == CH_STAR);
        if (need || $urandom_range(0, 3) == 0)
            text.push_back({8'($urandom_range(0, 32)), 1'b0});
        foreach (piece[i]) text.push_back({piece[i], 1'b0});
        piece.delete();
        tail_kind = kind;
    endfunction

    function automatic void add_end();
        commit(TAIL_OTHER);
        text.push_back({8'($urandom), 1'b1});
    endfunction

    function automatic void add_name(int len);
        add(rand_alpha());
        for (int i = 1; i < len; i++) add(rand_alnum());
    endfunction

    function automatic void add_number(int len);
        bit nines;
        nines = ($urandom_range(0, 2) == 0);
        for (int i = 0; i < len; i++)
            add(nines ? CH_NINE : 8'($urandom_range(CH_ZERO, CH_NINE)));
    endfunction

    function automatic void add_comment(bit closed);
        logic [7:0] prev;
        logic [7:0] b;
        int n;
        add(CH_SLASH);
        add(CH_STAR);
        if (closed && $urandom_range(0, 4) == 0) begin
            add(CH_SLASH);
            return;
        end
        n = ($urandom_range(0, 7) == 0) ? $urandom_range(10, 30) : $urandom_range(0, 6);
        prev = CH_STAR;
        for (int i = 0; i < n; i++) begin
            b = ($urandom_range(0, 4) == 0) ? CH_STAR : 8'($urandom_range(0, 255));
            if (prev == CH_STAR && b == CH_SLASH) b = CH_STAR;
            add(b);
            prev = b;
        end
        if (closed) begin
            add(CH_STAR);
            add(CH_SLASH);
        end
    endfunction

    function automatic void compose_token();
        int roll;
        string kw;
        roll = $urandom_range(0, 99);
        if (roll < 15) begin
            kw = sb.kw_text[$urandom_range(0, 11)];
            for (int i = 0; i < kw.len(); i++) add(kw[i]);
            commit(TAIL_WORD);
        end else if (roll < 22) begin
            // near misses of keywords
            kw = sb.kw_text[$urandom_range(0, 11)];
            if ($urandom_range(0, 1)) begin
                for (int i = 0; i < kw.len() - 1; i++) add(kw[i]);
            end else begin
                for (int i = 0; i < kw.len(); i++) add(kw[i]);
                add(rand_alnum());
            end
            commit(TAIL_WORD);
        end else if (roll < 37) begin
            add_name(($urandom_range(0, 5) == 0) ? NAME_MAX : $urandom_range(1, NAME_MAX));
            commit(TAIL_WORD);
        end else if (roll < 52) begin
            add_number(($urandom_range(0, 4) == 0) ? DIGITS_MAX
                                                    : $urandom_range(1, DIGITS_MAX));
            commit(TAIL_NUM);
        end else if (roll < 66) begin
            case ($urandom_range(0, 7))
                0:       add(CH_PLUS);
                1:       add(CH_MINUS);
                2:       add(CH_STAR);
                3:       add(CH_LPAREN);
                4:       add(CH_RPAREN);
                5:       add(CH_COMMA);
                6:       add(CH_SEMI);
                default: add(CH_EQUAL);
            endcase
            commit(TAIL_OTHER);
        end else if (roll < 78) begin
            case ($urandom_range(0, 3))
                0:       begin add(CH_COLON); add(CH_EQUAL); end
                1:       begin add(CH_LESS); add(CH_GREATER); end
                2:       begin add(CH_LESS); add(CH_EQUAL); end
                default: begin add(CH_GREATER); add(CH_EQUAL); end
            endcase
            commit(TAIL_OTHER);
        end else if (roll < 86) begin
            case ($urandom_range(0, 2))
                0:       begin add(CH_LESS); commit(TAIL_OTHER); end
                1:       begin add(CH_GREATER); commit(TAIL_OTHER); end
                default: begin add(CH_SLASH); commit(TAIL_SLASH); end
            endcase
        end else if (roll < 93) begin
            add_comment(1'b1);
            commit(TAIL_OTHER);
        end else begin
            repeat (($urandom_range(0, 9) == 0) ? $urandom_range(5, 20) : $urandom_range(1, 3))
                add(8'($urandom_range(0, 32)));
            commit(TAIL_OTHER);
        end
    endfunction

    // one way of ending the stream, chosen at random
    function automatic void close_stream();
        logic [7:0] b;
        case ($urandom_range(0, 5))
            0: begin
                ending = "a period";
                if ($urandom_range(0, 1)) begin
                    add_name($urandom_range(1, NAME_MAX));
                    commit(TAIL_WORD);
                end
                add(CH_PERIOD);
                commit(TAIL_OTHER);
            end
            1: begin
                ending = "end of input";
                case ($urandom_range(0, 4))
                    1: begin add_name($urandom_range(1, NAME_MAX)); commit(TAIL_WORD); end
                    2: begin add_number($urandom_range(1, DIGITS_MAX)); commit(TAIL_NUM); end
                    3: begin
                        case ($urandom_range(0, 2))
                            0:       add(CH_LESS);
                            1:       add(CH_GREATER);
                            default: add(CH_SLASH);
                        endcase
                        commit(TAIL_OTHER);
                    end
                    4: begin add_comment(1'b0); commit(TAIL_OTHER); end
                    default: ;
                endcase
                add_end();
            end
            2: begin
                ending = "an overlong name";
                add_name($urandom_range(NAME_MAX + 1, 20));
                commit(TAIL_WORD);
                if ($urandom_range(0, 1)) add_end();
                else begin add(CH_PLUS); commit(TAIL_OTHER); end
            end
            3: begin
                ending = "an overlong number";
                add_number($urandom_range(DIGITS_MAX + 1, 9));
                commit(TAIL_NUM);
                if ($urandom_range(0, 1)) add_end();
                else begin add(CH_SEMI); commit(TAIL_OTHER); end
            end
            4: begin
                ending = "a lone colon";
                add(CH_COLON);
                commit(TAIL_OTHER);
                if ($urandom_range(0, 1)) add_end();
                else begin add(rand_alnum()); commit(TAIL_OTHER); end
            end
            default: begin
                ending = "an invalid symbol";
                do b = 8'($urandom_range(33, 255));
                while (token_board::alpha(b) || token_board::numeral(b) ||
                       b inside {CH_LPAREN, CH_RPAREN, CH_STAR, CH_PLUS, CH_COMMA,
                                 CH_MINUS, CH_PERIOD, CH_SLASH, CH_COLON, CH_SEMI,
                                 CH_EQUAL, CH_LESS, CH_GREATER});
                add(b);
                commit(TAIL_OTHER);
            end
        endcase
    endfunction

    task automatic send_item(t_in_item it);
        int gap;
        push <= 1'b1;
        i_data <= it;
        do @(posedge i_clk); while (full);
        sent++;
        gap = pick_gap();
        if (gap > 0) begin
            push <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
    endtask

    task automatic ship();
        while (text.size() != 0) send_item(text.pop_front());
    endtask

    initial begin
        bit held;
        held = 1'b0;
        sb = new();
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // self-closing comment, zero byte, keyword, <>, largest number,
        // lone slash before a paren, comment holding 0xff, then :=
        put_text("/*/");
        text.push_back({8'h00, 1'b0});
        put_text("odd<>99999/(/*");
        text.push_back({8'hff, 1'b0});
        put_text("*/:=");
        ship();

        while (sent < N_ITEMS) begin
            compose_token();
            ship();
            if (!held && sent >= N_ITEMS / 2) begin
                // sender holds off until every token has been transferred
                held = 1'b1;
                push <= 1'b0;
                do @(posedge i_clk); while (sb.due.size() != 0);
            end
        end

        close_stream();
        // stopped: the rest is ignored
        repeat (3) text.push_back({8'($urandom), 1'b0});
        add_end();
        text.push_back({8'($urandom), 1'b0});
        ship();

        push <= 1'b0;
        do @(posedge i_clk); while (sb.due.size() != 0);
        repeat (10) @(posedge i_clk);

        $display("tb: %0d bytes transferred, %0d tokens checked", sb.inputs, sb.tokens);
        $display("tb: stream closed by %s, later bytes ignored", ending);
        if (sb.errors == 0) $display("tb: clean");
        else $display("tb: errors");
        $finish;
    end

endmodule

[sim.f]
+incdir+design
design/pl0ls_pkg.sv
design/pl0ls_front.sv
design/pl0ls_queue.sv
design/pl0ls_back.sv
design/pl0_lexical_scanner_top.sv
tb/sv/tb.sv
